// File: rtl/priority_task_scheduler_macros.svh
// assertion macros used by the checker file
`ifndef PRIORITY_TASK_SCHEDULER_MACROS_SVH
`define PRIORITY_TASK_SCHEDULER_MACROS_SVH

// checked property, ignored while reset is asserted
`define PTS_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("pts assertion failed");

// checked property, also evaluated during reset
`define PTS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("pts assertion failed");

`endif

// File: rtl/pts_pkg.sv
// shared types and constants of the priority task scheduler
package pts_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ID_W     = 16;
    localparam int PRIO_W   = 4;

    localparam logic [PRIO_W-1:0] MAX_PRIO = PRIO_W'(10);

    typedef enum logic {
        CMD_ENQ = 1'b0,
        CMD_DEQ = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [ID_W-1:0]   id;
    } t_entry;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic   ins;
        logic   del;
        t_entry item;
    } t_cell_ctl;

endpackage

// File: rtl/priority_task_scheduler.sv
// top level of the priority task scheduler
//
// Input channel (s side): tuser carries the command, 0 enqueue and 1 dequeue;
// tdata carries the task id and its priority. Output channel (m side): one
// transfer per input transfer, tdata is the removed task id (zero unless a
// dequeue succeeds) and tuser is the status: ok, empty, priority out of range
// or store full.
// Tasks sit in a chain of cells kept sorted by priority, highest first, and
// by arrival among equal priorities. An enqueue compares the new task with
// every cell at once and each cell holds, takes the new task or takes its
// upstream neighbor; a dequeue pops the head cell while all others move up.
// The result is shown in the cycle after the input transfer, and one item is
// taken every cycle unless the receiver stalls; the combinational compare in
// each cell and the one-entry output register set that behaviour.
// Reset empties the store and drops any pending result; tready is low while
// reset is asserted. If the receiver stalls, the result holds in the output
// register and a new input is taken only in a cycle in which it drains.
module priority_task_scheduler import pts_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // [15:0] task_id, [19:16] task_priority, rest zero
    input  logic [0:0]  i_s_tuser,   // [0] cmd
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [15:0] out_task_id
    output logic [1:0]  o_m_tuser    // [1:0] status
);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    logic [ID_W-1:0]  r_out_id;
    t_status          r_out_status;
    logic [ID_W-1:0]  n_out_id;
    t_status          n_out_status;

    logic             w_accept;
    t_cmd             w_cmd;
    t_cell_ctl        w_ctl;
    t_entry           w_entry [CAPACITY];
    logic             w_keep  [CAPACITY];
    logic             w_in_use [CAPACITY];

    // input transfer
    assign o_s_tready = i_rst_n && (!r_out_valid || i_m_tready);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_cmd      = t_cmd'(i_s_tuser[0]);

    // decode the command, pick status and cell operation
    always_comb begin
        w_ctl.ins       = 1'b0;
        w_ctl.del       = 1'b0;
        w_ctl.item.id   = i_s_tdata[ID_W-1:0];
        w_ctl.item.prio = i_s_tdata[ID_W+PRIO_W-1:ID_W];
        n_out_id        = '0;
        n_out_status    = ST_OK;
        n_count         = r_count;
        case (w_cmd)
            CMD_ENQ: begin
                if (w_ctl.item.prio > MAX_PRIO) begin
                    n_out_status = ST_RANGE;
                end else if (r_count == CNT_W'(CAPACITY)) begin
                    n_out_status = ST_FULL;
                end else begin
                    w_ctl.ins = w_accept;
                    n_count   = r_count + CNT_W'(1);
                end
            end
            CMD_DEQ: begin
                if (r_count == '0) begin
                    n_out_status = ST_EMPTY;
                end else begin
                    w_ctl.del = w_accept;
                    n_out_id  = w_entry[0].id;
                    n_count   = r_count - CNT_W'(1);
                end
            end
            default: begin
                n_out_status = ST_OK;
            end
        endcase
    end

    // chain of cells, head at index zero
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        t_entry w_prev;
        logic   w_prev_keep;
        t_entry w_next;

        assign w_in_use[i] = (CNT_W'(i) < r_count);

        if (i == 0) begin : g_head
            assign w_prev      = w_ctl.item;
            assign w_prev_keep = 1'b1;
        end else begin : g_body
            assign w_prev      = w_entry[i-1];
            assign w_prev_keep = w_keep[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign w_next = '0;
        end else begin : g_inner
            assign w_next = w_entry[i+1];
        end

        pts_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_in_use    (w_in_use[i]),
            .i_prev      (w_prev),
            .i_prev_keep (w_prev_keep),
            .i_next      (w_next),
            .o_entry     (w_entry[i]),
            .o_keep      (w_keep[i])
        );
    end

    // fill count and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_id     <= n_out_id;
            r_out_status <= n_out_status;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_id;
    assign o_m_tuser  = r_out_status;

endmodule

// File: rtl/pts_cell.sv
// one slot of the sorted task chain
module pts_cell import pts_pkg::*; (
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_in_use,     // slot index below the fill count
    input  t_entry    i_prev,       // entry of the neighbor nearer the head
    input  logic      i_prev_keep,  // neighbor nearer the head keeps its entry
    input  t_entry    i_next,       // entry of the neighbor nearer the tail
    output t_entry    o_entry,
    output logic      o_keep
);

    t_entry r_entry;
    t_entry n_entry;

    // an occupied slot ranks at or above the new task: it stays put
    assign o_keep  = i_in_use && (r_entry.prio >= i_ctl.item.prio);
    assign o_entry = r_entry;

    // insert: hold, take the new task, or take the neighbor pushed down
    // remove: every slot takes the entry behind it
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins) begin
            if (o_keep) begin
                n_entry = r_entry;
            end else if (i_prev_keep) begin
                n_entry = i_ctl.item;
            end else begin
                n_entry = i_prev;
            end
        end else if (i_ctl.del) begin
            n_entry = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// File: rtl/pts_checker.sv
// port-level checks of the priority task scheduler
`include "priority_task_scheduler_macros.svh"

module pts_checker import pts_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [23:0] i_s_tdata,
    input logic [0:0]  i_s_tuser,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata,
    input logic [1:0]  o_m_tuser
);

    // reset drops any pending result
    `PTS_ASSERT_ALWAYS(a_rst_clears, i_clk, !i_rst_n |=> !o_m_tvalid)

    // every input transfer shows its result in the next cycle
    `PTS_ASSERT(a_result_next, i_clk, i_rst_n, (i_s_tvalid && o_s_tready) |=> o_m_tvalid)

    // a rejected priority reports the range status
    `PTS_ASSERT(a_range_status, i_clk, i_rst_n, (i_s_tvalid && o_s_tready && (i_s_tuser[0] == CMD_ENQ) && (i_s_tdata[19:16] > MAX_PRIO)) |=> (o_m_tuser == ST_RANGE))

    // only a successful transfer carries a task id
    `PTS_ASSERT(a_id_zero, i_clk, i_rst_n, (o_m_tvalid && (o_m_tuser != ST_OK)) |-> (o_m_tdata == '0))

    // a stalled result holds
    `PTS_ASSERT(a_stall_hold, i_clk, i_rst_n, (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser)))

endmodule

bind priority_task_scheduler pts_checker u_pts_checker (.*);
